@@ rtl/assert_macros.svh @@
// Assertion macros for the port-level checker of the heading controller.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define HPC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define HPC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/hpc_pkg.sv @@
// Package for the heading turn PI controller: field widths, request and
// status codes, register indexes, reset values and shared struct types.
`default_nettype none

package hpc_pkg;

   // Field widths
   localparam int REQ_W      = 2;
   localparam int YAW_W      = 16;
   localparam int GOAL_W     = 17;
   localparam int VEL_W      = 12;
   localparam int CMD_VEL_W  = 13;
   localparam int STAT_W     = 3;
   localparam int GAIN_W     = 20;
   localparam int BAND_W     = 15;
   localparam int GAP_W      = 17;
   localparam int INTEG_W    = 32;
   localparam int FRAC_W     = 16;
   localparam int ACC_W      = 53;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;

   // Request codes
   localparam logic [REQ_W-1:0] REQ_TICK   = 2'd0;
   localparam logic [REQ_W-1:0] REQ_START  = 2'd1;
   localparam logic [REQ_W-1:0] REQ_CANCEL = 2'd2;

   // Status codes
   localparam logic [STAT_W-1:0] ST_IDLE      = 3'd0;
   localparam logic [STAT_W-1:0] ST_TURNING   = 3'd1;
   localparam logic [STAT_W-1:0] ST_REACHED   = 3'd2;
   localparam logic [STAT_W-1:0] ST_CANCELLED = 3'd3;
   localparam logic [STAT_W-1:0] ST_IN_BAND   = 3'd4;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PROP_GAIN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INTEG_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VEL    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_VEL    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DEAD_BAND  = 3'd4;

   // Register reset values
   localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = 20'd11141;
   localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = 20'd0;
   localparam logic [VEL_W-1:0]  MAX_VEL_RST    = 12'd1150;
   localparam logic [VEL_W-1:0]  MIN_VEL_RST    = 12'd300;
   localparam logic [BAND_W-1:0] DEAD_BAND_RST  = 15'd250;

   // Sequencer states
   typedef enum logic [3:0] {
      S_IDLE,
      S_TARGET,
      S_GAP,
      S_CHECK,
      S_MUL_P,
      S_MUL_I,
      S_CLAMP,
      S_RAISE,
      S_MUL_K,
      S_DIV,
      S_EMIT
   } fsm_state_type;

   // Control into the serial multiply-accumulate unit
   typedef struct packed {
      logic load;
      logic keep_acc;
   } mac_ctrl_type;

   // Status out of a serial unit
   typedef struct packed {
      logic busy;
      logic done;
   } unit_stat_type;

endpackage

`default_nettype wire

@@ rtl/hpc_if.sv @@
// Valid/ready channel interfaces for the heading controller requests and results.
// Depends on hpc_pkg for field widths.
`default_nettype none

interface hpc_req_if import hpc_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic [REQ_W-1:0]         req_type;
   logic signed [YAW_W-1:0]  yaw_now;
   logic signed [GOAL_W-1:0] goal_turn;
   logic                     use_fixed_speed;
   logic [VEL_W-1:0]         fixed_speed;
   logic                     to_smoother;

   modport source (output valid, req_type, yaw_now, goal_turn, use_fixed_speed,
                   fixed_speed, to_smoother, input ready);
   modport sink   (input valid, req_type, yaw_now, goal_turn, use_fixed_speed,
                   fixed_speed, to_smoother, output ready);
endinterface

interface hpc_rsp_if import hpc_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic signed [CMD_VEL_W-1:0] velocity_cmd;
   logic                        route_smoother;
   logic [STAT_W-1:0]           status;

   modport source (output valid, velocity_cmd, route_smoother, status, input ready);
   modport sink   (input valid, velocity_cmd, route_smoother, status, output ready);
endinterface

`default_nettype wire

@@ rtl/heading_turn_pi_controller_unit.sv @@
// Top level of the heading turn PI controller: sequencer, state and datapath.
// Depends on hpc_pkg, hpc_if, hpc_mac and hpc_div.
//
// Channel   Dir  Handshake      Beat
// req_chan  in   valid/ready    one request: tick, start, cancel
// rsp_chan  out  valid/ready    one result per request
// csr_*     in   write enable   one register write, no read-back
//
// Start: target, gap, dead band check, emit. Cancel, spare code and idle tick
// go straight to emit. Reached or fixed-speed tick: gap, check, emit. PI tick:
// gap, check, bit-serial MAC passes by prop_gain and integ_gain, clamp, raise,
// MAC pass by the ramp factor, bit-serial divide, emit; each MAC pass ends once
// no multiplier bits remain. One request is in flight at a time.
// A waiting result holds in the output register while the next request runs.
// Synchronous reset; only configuration and control registers are reset.
`default_nettype none

module heading_turn_pi_controller_unit import hpc_pkg::*; #(
   parameter int unsigned RAMP_STEPS = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   hpc_req_if.sink               req_chan,
   hpc_rsp_if.source             rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int KW    = $clog2(RAMP_STEPS + 1);
   localparam int S_W   = VEL_W + KW;
   localparam int CMD_W = VEL_W + FRAC_W + 1;
   localparam int MAG_W = VEL_W + FRAC_W;
   localparam logic [KW-1:0]         RAMP_INIT = KW'(RAMP_STEPS);
   localparam logic [S_W+FRAC_W-1:0] HALF_D    = (S_W + FRAC_W)'(RAMP_STEPS) << (FRAC_W - 1);
   localparam logic signed [17:0]    HALF_TURN = 18'sd18000;
   localparam logic signed [17:0]    FULL_TURN = 18'sd36000;

   // Wrap an angle once into the half-turn range
   function automatic logic signed [17:0] wrap18(input logic signed [17:0] a);
      if (a < -HALF_TURN) begin
         return a + FULL_TURN;
      end else if (a > HALF_TURN) begin
         return a - FULL_TURN;
      end
      return a;
   endfunction

   // Configuration registers
   logic [GAIN_W-1:0] prop_gain_ff, integ_gain_ff;
   logic [VEL_W-1:0]  max_vel_ff, min_vel_ff;
   logic [BAND_W-1:0] dead_band_ff;

   // Controller state
   fsm_state_type             state_ff, state_in;
   logic                      turning_ff, turning_in;
   logic signed [YAW_W-1:0]   target_ff, target_in;
   logic signed [INTEG_W-1:0] integ_ff, integ_in;
   logic [KW-1:0]             ramp_ff, ramp_in;
   logic                      fixed_mode_ff, fixed_mode_in;
   logic signed [CMD_VEL_W-1:0] fixed_cmd_ff, fixed_cmd_in;
   logic                      route_ff, route_in;
   logic                      rsp_valid_ff, rsp_valid_in;

   // Request beat and working values
   logic [REQ_W-1:0]          type_ff, type_in;
   logic signed [YAW_W-1:0]   yaw_ff, yaw_in;
   logic signed [GOAL_W-1:0]  goal_ff, goal_in;
   logic                      use_fixed_ff, use_fixed_in;
   logic [VEL_W-1:0]          speed_ff, speed_in;
   logic                      smoother_ff, smoother_in;
   logic signed [YAW_W-1:0]   base_ff, base_in;
   logic signed [GAP_W-1:0]   gap_ff, gap_in;
   logic signed [CMD_W-1:0]   clamp_ff, clamp_in;
   logic                      neg_ff, neg_in;
   logic signed [CMD_VEL_W-1:0] res_vel_ff, res_vel_in;
   logic                      res_route_ff, res_route_in;
   logic [STAT_W-1:0]         res_status_ff, res_status_in;
   logic signed [CMD_VEL_W-1:0] rsp_vel_ff, rsp_vel_in;
   logic                      rsp_route_ff, rsp_route_in;
   logic [STAT_W-1:0]         rsp_status_ff, rsp_status_in;

   // Datapath nets
   logic                      accept;
   logic signed [17:0]        sum18, twrap, diff18, gwrap;
   logic [GAP_W-1:0]          gap_abs;
   logic                      in_band;
   logic signed [INTEG_W:0]   integ_sum;
   logic signed [INTEG_W-1:0] integ_sat;
   logic signed [ACC_W-1:0]   maxq, neg_maxq;
   logic signed [CMD_W-1:0]   clamp_val, minq, raised;
   logic [MAG_W-1:0]          raised_mag;
   logic [S_W+FRAC_W-1:0]     rnd_sum;
   logic [CMD_VEL_W-1:0]      qvel;
   logic [KW-1:0]             ramp_k;
   logic                      goal_pos;
   logic [CMD_VEL_W-1:0]      spd13;

   // Unit hookups
   mac_ctrl_type              mac_ctrl;
   logic signed [ACC_W-1:0]   mac_mcand;
   logic [GAIN_W-1:0]         mac_mplier;
   logic signed [ACC_W-1:0]   mac_acc;
   unit_stat_type             mac_stat;
   logic                      div_start;
   logic [S_W-1:0]            div_quot;
   unit_stat_type             div_stat;

   hpc_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .mcand  (mac_mcand),
      .mplier (mac_mplier),
      .acc    (mac_acc),
      .stat   (mac_stat)
   );

   hpc_div #(
      .DIVISOR (RAMP_STEPS),
      .DVD_W   (S_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rnd_sum[S_W+FRAC_W-1:FRAC_W]),
      .quotient (div_quot),
      .stat     (div_stat)
   );

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff  <= PROP_GAIN_RST;
         integ_gain_ff <= INTEG_GAIN_RST;
         max_vel_ff    <= MAX_VEL_RST;
         min_vel_ff    <= MIN_VEL_RST;
         dead_band_ff  <= DEAD_BAND_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PROP_GAIN:  prop_gain_ff  <= csr_data[GAIN_W-1:0];
            CSR_INTEG_GAIN: integ_gain_ff <= csr_data[GAIN_W-1:0];
            CSR_MAX_VEL:    max_vel_ff    <= csr_data[VEL_W-1:0];
            CSR_MIN_VEL:    min_vel_ff    <= csr_data[VEL_W-1:0];
            CSR_DEAD_BAND:  dead_band_ff  <= csr_data[BAND_W-1:0];
            default: ;
         endcase
      end
   end

   // Target and gap, each wrapped once
   assign sum18  = {{2{yaw_ff[YAW_W-1]}}, yaw_ff} + {goal_ff[GOAL_W-1], goal_ff};
   assign twrap  = wrap18(sum18);
   assign diff18 = {{2{base_ff[YAW_W-1]}}, base_ff} - {{2{yaw_ff[YAW_W-1]}}, yaw_ff};
   assign gwrap  = wrap18(diff18);

   // Dead band test
   assign gap_abs = gap_ff[GAP_W-1] ? GAP_W'(-gap_ff) : GAP_W'(gap_ff);
   assign in_band = (gap_abs <= {{(GAP_W-BAND_W){1'b0}}, dead_band_ff});

   // Saturating integral update
   assign integ_sum = {integ_ff[INTEG_W-1], integ_ff}
                    + {{(INTEG_W+1-GAP_W){gap_ff[GAP_W-1]}}, gap_ff};
   always_comb begin
      if (integ_sum[INTEG_W] != integ_sum[INTEG_W-1]) begin
         integ_sat = integ_sum[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}}
                                        : {1'b0, {(INTEG_W-1){1'b1}}};
      end else begin
         integ_sat = integ_sum[INTEG_W-1:0];
      end
   end

   // Clamp to the maximum speed
   assign maxq     = $signed({{(ACC_W-MAG_W){1'b0}}, max_vel_ff, {FRAC_W{1'b0}}});
   assign neg_maxq = -maxq;
   always_comb begin
      if (mac_acc > maxq) begin
         clamp_val = maxq[CMD_W-1:0];
      end else if (mac_acc < neg_maxq) begin
         clamp_val = neg_maxq[CMD_W-1:0];
      end else begin
         clamp_val = mac_acc[CMD_W-1:0];
      end
   end

   // Raise a nonzero command to the minimum speed
   assign minq = $signed({1'b0, min_vel_ff, {FRAC_W{1'b0}}});
   always_comb begin
      if ((clamp_ff > 0) && (clamp_ff < minq)) begin
         raised = minq;
      end else if ((clamp_ff < 0) && (clamp_ff > -minq)) begin
         raised = -minq;
      end else begin
         raised = clamp_ff;
      end
   end
   assign raised_mag = raised[CMD_W-1] ? MAG_W'(-raised) : MAG_W'(raised);

   // Ramp factor, rounding offset and signed quotient
   assign ramp_k   = RAMP_INIT - ramp_ff;
   assign rnd_sum  = mac_acc[S_W+FRAC_W-1:0] + HALF_D;
   assign qvel     = {1'b0, div_quot[VEL_W-1:0]};
   assign goal_pos = !goal_ff[GOAL_W-1] && (goal_ff != '0);
   assign spd13    = {1'b0, speed_ff};

   assign accept        = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);

   // Sequencer: next state, state updates and unit control
   always_comb begin
      state_in      = state_ff;
      turning_in    = turning_ff;
      target_in     = target_ff;
      integ_in      = integ_ff;
      ramp_in       = ramp_ff;
      fixed_mode_in = fixed_mode_ff;
      fixed_cmd_in  = fixed_cmd_ff;
      route_in      = route_ff;
      type_in       = type_ff;
      yaw_in        = yaw_ff;
      goal_in       = goal_ff;
      use_fixed_in  = use_fixed_ff;
      speed_in      = speed_ff;
      smoother_in   = smoother_ff;
      base_in       = base_ff;
      gap_in        = gap_ff;
      clamp_in      = clamp_ff;
      neg_in        = neg_ff;
      res_vel_in    = res_vel_ff;
      res_route_in  = res_route_ff;
      res_status_in = res_status_ff;
      rsp_vel_in    = rsp_vel_ff;
      rsp_route_in  = rsp_route_ff;
      rsp_status_in = rsp_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      mac_ctrl      = '0;
      mac_mcand     = '0;
      mac_mplier    = '0;
      div_start     = 1'b0;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               type_in      = req_chan.req_type;
               yaw_in       = req_chan.yaw_now;
               goal_in      = req_chan.goal_turn;
               use_fixed_in = req_chan.use_fixed_speed;
               speed_in     = req_chan.fixed_speed;
               smoother_in  = req_chan.to_smoother;
               res_vel_in   = '0;
               case (req_chan.req_type)
                  REQ_START: begin
                     state_in = S_TARGET;
                  end
                  REQ_TICK: begin
                     if (turning_ff) begin
                        base_in  = target_ff;
                        state_in = S_GAP;
                     end else begin
                        res_route_in  = route_ff;
                        res_status_in = ST_IDLE;
                        state_in      = S_EMIT;
                     end
                  end
                  REQ_CANCEL: begin
                     res_route_in  = 1'b0;
                     res_status_in = turning_ff ? ST_CANCELLED : ST_IDLE;
                     turning_in    = 1'b0;
                     state_in      = S_EMIT;
                  end
                  default: begin
                     res_route_in  = 1'b0;
                     res_status_in = turning_ff ? ST_TURNING : ST_IDLE;
                     state_in      = S_EMIT;
                  end
               endcase
            end
         end
         S_TARGET: begin
            base_in  = twrap[YAW_W-1:0];
            state_in = S_GAP;
         end
         S_GAP: begin
            gap_in   = gwrap[GAP_W-1:0];
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (type_ff == REQ_START) begin
               target_in = base_ff;
               state_in  = S_EMIT;
               if (in_band) begin
                  turning_in    = 1'b0;
                  res_route_in  = 1'b0;
                  res_status_in = ST_IN_BAND;
               end else begin
                  turning_in    = 1'b1;
                  integ_in      = '0;
                  ramp_in       = RAMP_INIT;
                  fixed_mode_in = use_fixed_ff;
                  fixed_cmd_in  = goal_pos ? $signed(spd13) : -$signed(spd13);
                  route_in      = smoother_ff;
                  res_route_in  = smoother_ff;
                  res_status_in = ST_TURNING;
               end
            end else if (in_band) begin
               turning_in    = 1'b0;
               integ_in      = '0;
               target_in     = '0;
               res_route_in  = route_ff;
               res_status_in = ST_REACHED;
               state_in      = S_EMIT;
            end else if (fixed_mode_ff) begin
               res_vel_in    = fixed_cmd_ff;
               res_route_in  = route_ff;
               res_status_in = ST_TURNING;
               state_in      = S_EMIT;
            end else begin
               integ_in   = integ_sat;
               ramp_in    = (ramp_ff != '0) ? ramp_ff - 1'b1 : '0;
               mac_ctrl.load = 1'b1;
               mac_mcand  = {{(ACC_W-GAP_W){gap_ff[GAP_W-1]}}, gap_ff};
               mac_mplier = prop_gain_ff;
               state_in   = S_MUL_P;
            end
         end
         S_MUL_P: begin
            if (mac_stat.done) begin
               mac_ctrl.load     = 1'b1;
               mac_ctrl.keep_acc = 1'b1;
               mac_mcand  = {{(ACC_W-INTEG_W){integ_ff[INTEG_W-1]}}, integ_ff};
               mac_mplier = integ_gain_ff;
               state_in   = S_MUL_I;
            end
         end
         S_MUL_I: begin
            if (mac_stat.done) begin
               state_in = S_CLAMP;
            end
         end
         S_CLAMP: begin
            clamp_in = clamp_val;
            state_in = S_RAISE;
         end
         S_RAISE: begin
            neg_in        = raised[CMD_W-1];
            mac_ctrl.load = 1'b1;
            mac_mcand     = {{(ACC_W-MAG_W){1'b0}}, raised_mag};
            mac_mplier    = {{(GAIN_W-KW){1'b0}}, ramp_k};
            state_in      = S_MUL_K;
         end
         S_MUL_K: begin
            if (mac_stat.done) begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_stat.done) begin
               res_vel_in    = neg_ff ? $signed(-qvel) : $signed(qvel);
               res_route_in  = route_ff;
               res_status_in = ST_TURNING;
               state_in      = S_EMIT;
            end
         end
         S_EMIT: begin
            // Hold until the output register is free
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_vel_in    = res_vel_ff;
               rsp_route_in  = res_route_ff;
               rsp_status_in = res_status_ff;
               rsp_valid_in  = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // State register and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         turning_ff    <= 1'b0;
         target_ff     <= '0;
         integ_ff      <= '0;
         ramp_ff       <= RAMP_INIT;
         fixed_mode_ff <= 1'b0;
         fixed_cmd_ff  <= '0;
         route_ff      <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         turning_ff    <= turning_in;
         target_ff     <= target_in;
         integ_ff      <= integ_in;
         ramp_ff       <= ramp_in;
         fixed_mode_ff <= fixed_mode_in;
         fixed_cmd_ff  <= fixed_cmd_in;
         route_ff      <= route_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      yaw_ff        <= yaw_in;
      goal_ff       <= goal_in;
      use_fixed_ff  <= use_fixed_in;
      speed_ff      <= speed_in;
      smoother_ff   <= smoother_in;
      base_ff       <= base_in;
      gap_ff        <= gap_in;
      clamp_ff      <= clamp_in;
      neg_ff        <= neg_in;
      res_vel_ff    <= res_vel_in;
      res_route_ff  <= res_route_in;
      res_status_ff <= res_status_in;
      rsp_vel_ff    <= rsp_vel_in;
      rsp_route_ff  <= rsp_route_in;
      rsp_status_ff <= rsp_status_in;
   end

   // Drive the result channel
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.velocity_cmd   = rsp_vel_ff;
   assign rsp_chan.route_smoother = rsp_route_ff;
   assign rsp_chan.status         = rsp_status_ff;

endmodule

`default_nettype wire

@@ rtl/hpc_mac.sv @@
// Bit-serial shift-add multiply-accumulate unit, one multiplier bit per cycle.
// Depends on hpc_pkg for widths and the control/status structs.
`default_nettype none

module hpc_mac import hpc_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  mac_ctrl_type             ctrl,
   input  logic signed [ACC_W-1:0]  mcand,
   input  logic [GAIN_W-1:0]        mplier,
   output logic signed [ACC_W-1:0]  acc,
   output unit_stat_type            stat
);

   logic                    busy_ff, busy_in;
   logic signed [ACC_W-1:0] mcand_ff, mcand_in;
   logic [GAIN_W-1:0]       mplier_ff, mplier_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;

   // Load a new pass, or add the shifted multiplicand for each set bit
   always_comb begin
      busy_in   = busy_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (ctrl.load) begin
         mcand_in  = mcand;
         mplier_in = mplier;
         acc_in    = ctrl.keep_acc ? acc_ff : '0;
         busy_in   = 1'b1;
      end else if (busy_ff) begin
         if (mplier_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in  = mcand_ff <<< 1;
            mplier_in = mplier_ff >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   // Done once no multiplier bits remain
   assign acc       = acc_ff;
   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && (mplier_ff == '0);

endmodule

`default_nettype wire

@@ rtl/hpc_div.sv @@
// Bit-serial restoring divider by a fixed divisor, one quotient bit per cycle.
// Depends on hpc_pkg for the status struct.
`default_nettype none

module hpc_div import hpc_pkg::*; #(
   parameter int unsigned DIVISOR = 15,
   parameter int unsigned DVD_W   = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   output logic [DVD_W-1:0] quotient,
   output unit_stat_type    stat
);

   localparam int REM_W = $clog2(DIVISOR + 1);
   localparam int CNT_W = $clog2(DVD_W + 1);
   localparam logic [REM_W:0]   DIV_K = (REM_W + 1)'(DIVISOR);
   localparam logic [CNT_W-1:0] STEPS = CNT_W'(DVD_W);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVD_W-1:0] work_ff, work_in;
   logic [REM_W-1:0] rem_ff, rem_in;
   logic [REM_W:0]   trial;
   logic [REM_W:0]   diff;
   logic             geq;

   // Bring down the next dividend bit and try the subtraction
   assign trial = {rem_ff, work_ff[DVD_W-1]};
   assign geq   = (trial >= DIV_K);
   assign diff  = trial - DIV_K;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = STEPS;
         work_in = dividend;
         rem_in  = '0;
      end else if (busy_ff) begin
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
         end else begin
            cnt_in  = cnt_ff - 1'b1;
            work_in = {work_ff[DVD_W-2:0], geq};
            rem_in  = geq ? diff[REM_W-1:0] : trial[REM_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff  <= cnt_in;
      work_ff <= work_in;
      rem_ff  <= rem_in;
   end

   assign quotient  = work_ff;
   assign stat.busy = busy_ff;
   assign stat.done = busy_ff && (cnt_ff == '0);

endmodule

`default_nettype wire

@@ rtl/hpc_checker.sv @@
// Port-level checker for the heading controller, bound to the top level.
// Depends on hpc_pkg for status codes and assert_macros.svh for the macros.
`default_nettype none

`include "assert_macros.svh"

module hpc_checker import hpc_pkg::*; (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic signed [CMD_VEL_W-1:0] rsp_velocity_cmd,
   input logic                        rsp_route_smoother,
   input logic [STAT_W-1:0]           rsp_status
);

   // A stalled result beat holds
   `HPC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_velocity_cmd) && $stable(rsp_route_smoother) && $stable(rsp_status), "result beat changed while stalled")

   // One request in flight: ready drops after each accepted beat
   `HPC_ASSERT_NXT(a_one_in_flight, clock, reset, req_valid && req_ready, !req_ready, "request accepted while another is in flight")

   // Only a turning result carries a velocity
   `HPC_ASSERT_IMP(a_vel_when_turning, clock, reset, rsp_valid && (rsp_velocity_cmd != '0), rsp_status == ST_TURNING, "velocity on a result that is not turning")

   // A start inside the dead band is quiet and unrouted
   `HPC_ASSERT_IMP(a_in_band_quiet, clock, reset, rsp_valid && (rsp_status == ST_IN_BAND), (rsp_velocity_cmd == '0) && !rsp_route_smoother, "dead band start carries velocity or route")

endmodule

bind heading_turn_pi_controller_unit hpc_checker u_hpc_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_velocity_cmd   (rsp_chan.velocity_cmd),
   .rsp_route_smoother (rsp_chan.route_smoother),
   .rsp_status         (rsp_chan.status)
);

`default_nettype wire

@@ verif/turn_cmd_checker.sv @@
// Scoreboard for the heading turn controller: follows register writes and request beats,
// predicts each result beat and compares it field by field with the block output.
// Depends on hpc_pkg and the channel interfaces in hpc_if.

module turn_cmd_checker import hpc_pkg::*; #(
   parameter int unsigned RAMP_STEPS = 15
) (
   input  logic                  clock,
   input  logic                  reset,
   hpc_req_if                    req_mon,
   hpc_rsp_if                    rsp_mon,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output int unsigned           fail_count,
   output int unsigned           pending
);

   localparam longint INTEG_HI = 64'sd2147483647;
   localparam longint INTEG_LO = -64'sd2147483648;

   typedef struct packed {
      logic signed [CMD_VEL_W-1:0] vel;
      logic                        route;
      logic [STAT_W-1:0]           status;
   } turn_result_t;

   // Register copies
   logic [GAIN_W-1:0] kp;
   logic [GAIN_W-1:0] ki;
   logic [VEL_W-1:0]  vmax;
   logic [VEL_W-1:0]  vmin;
   logic [BAND_W-1:0] band;

   // Controller state copies
   logic                        turning;
   logic signed [YAW_W-1:0]     target;
   logic signed [INTEG_W-1:0]   err_sum;
   int unsigned                 ramp_left;
   logic                        fixed_mode;
   logic signed [CMD_VEL_W-1:0] fixed_cmd;
   logic                        route_reg;

   turn_result_t expected_cmds[$];
   turn_result_t want;

   function automatic longint wrap_half_turn(longint a);
      if (a < -18000) return a + 36000;
      if (a > 18000) return a - 36000;
      return a;
   endfunction

   function automatic longint abs_l(longint a);
      return (a < 0) ? -a : a;
   endfunction

   // Advance the state copy by one request and return the command it produces
   function automatic turn_result_t predict_command(
      input logic [REQ_W-1:0]         kind,
      input logic signed [YAW_W-1:0]  yaw,
      input logic signed [GOAL_W-1:0] goal,
      input logic                     use_fixed,
      input logic [VEL_W-1:0]         speed,
      input logic                     smooth
   );
      turn_result_t res;
      longint yaw_l, goal_l, gap, acc, cmd, lim_hi, lim_lo, scaled, mag, div, q;
      logic signed [YAW_W-1:0] tgt;
      yaw_l      = longint'(yaw);
      res.vel    = '0;
      res.route  = 1'b0;
      res.status = ST_IDLE;
      case (kind)
         REQ_START: begin
            goal_l = longint'(goal);
            tgt    = YAW_W'(wrap_half_turn(yaw_l + goal_l));
            target = tgt;
            gap    = wrap_half_turn(longint'(tgt) - yaw_l);
            if (abs_l(gap) <= longint'(band)) begin
               turning    = 1'b0;
               res.status = ST_IN_BAND;
            end else begin
               turning    = 1'b1;
               err_sum    = '0;
               ramp_left  = RAMP_STEPS;
               fixed_mode = use_fixed;
               fixed_cmd  = (goal_l > 0) ? $signed({1'b0, speed}) : -$signed({1'b0, speed});
               route_reg  = smooth;
               res.route  = smooth;
               res.status = ST_TURNING;
            end
         end
         REQ_CANCEL: begin
            res.status = turning ? ST_CANCELLED : ST_IDLE;
            turning    = 1'b0;
         end
         REQ_TICK: begin
            res.route = route_reg;
            if (turning) begin
               gap = wrap_half_turn(longint'(target) - yaw_l);
               if (abs_l(gap) <= longint'(band)) begin
                  // Arrived: end the turn and drop the target
                  turning    = 1'b0;
                  err_sum    = '0;
                  target     = '0;
                  res.status = ST_REACHED;
               end else if (fixed_mode) begin
                  res.vel    = fixed_cmd;
                  res.status = ST_TURNING;
               end else begin
                  // Saturate the integral at 32 bits
                  acc = longint'(err_sum) + gap;
                  if (acc > INTEG_HI) acc = INTEG_HI;
                  if (acc < INTEG_LO) acc = INTEG_LO;
                  err_sum = INTEG_W'(acc);
                  cmd     = longint'(kp) * gap + longint'(ki) * longint'(err_sum);
                  // Clamp to the maximum, then lift to the minimum (minimum wins)
                  lim_hi = longint'(vmax) * 65536;
                  lim_lo = longint'(vmin) * 65536;
                  if (cmd > lim_hi) cmd = lim_hi;
                  if (cmd < -lim_hi) cmd = -lim_hi;
                  if (cmd > 0 && cmd < lim_lo) cmd = lim_lo;
                  else if (cmd < 0 && cmd > -lim_lo) cmd = -lim_lo;
                  // Ramp in, then round to nearest with ties away from zero
                  if (ramp_left > 0) ramp_left--;
                  scaled     = cmd * longint'(RAMP_STEPS - ramp_left);
                  div        = longint'(RAMP_STEPS) * 65536;
                  mag        = abs_l(scaled);
                  q          = (mag + div / 2) / div;
                  res.vel    = CMD_VEL_W'((scaled < 0) ? -q : q);
                  res.status = ST_TURNING;
               end
            end
         end
         default: begin
            res.status = turning ? ST_TURNING : ST_IDLE;
         end
      endcase
      return res;
   endfunction

   // Track writes, check result beats, queue predictions for request beats
   always @(posedge clock) begin
      if (reset) begin
         kp         = PROP_GAIN_RST;
         ki         = INTEG_GAIN_RST;
         vmax       = MAX_VEL_RST;
         vmin       = MIN_VEL_RST;
         band       = DEAD_BAND_RST;
         turning    = 1'b0;
         target     = '0;
         err_sum    = '0;
         ramp_left  = RAMP_STEPS;
         fixed_mode = 1'b0;
         fixed_cmd  = '0;
         route_reg  = 1'b0;
         expected_cmds.delete();
         fail_count = 0;
         pending    = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PROP_GAIN:  kp   = csr_data[GAIN_W-1:0];
               CSR_INTEG_GAIN: ki   = csr_data[GAIN_W-1:0];
               CSR_MAX_VEL:    vmax = csr_data[VEL_W-1:0];
               CSR_MIN_VEL:    vmin = csr_data[VEL_W-1:0];
               CSR_DEAD_BAND:  band = csr_data[BAND_W-1:0];
               default: ;
            endcase
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_cmds.size() == 0) begin
               $error("unexpected result beat: velocity_cmd %0d, route_smoother %0d, status %0d",
                      rsp_mon.velocity_cmd, rsp_mon.route_smoother, rsp_mon.status);
               fail_count++;
            end else begin
               want = expected_cmds.pop_front();
               if (rsp_mon.velocity_cmd !== want.vel) begin
                  $error("velocity_cmd: expected %0d, actual %0d", want.vel,
                         rsp_mon.velocity_cmd);
                  fail_count++;
               end
               if (rsp_mon.route_smoother !== want.route) begin
                  $error("route_smoother: expected %0d, actual %0d", want.route,
                         rsp_mon.route_smoother);
                  fail_count++;
               end
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_mon.status);
                  fail_count++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_cmds.push_back(predict_command(req_mon.req_type, req_mon.yaw_now,
               req_mon.goal_turn, req_mon.use_fixed_speed, req_mon.fixed_speed,
               req_mon.to_smoother));
         end
         pending = expected_cmds.size();
      end
   end

endmodule

@@ verif/tb_top.sv @@
// Testbench top for the heading turn PI controller: clock, reset, request and
// register stimulus, result back-pressure and the verdict.
// Depends on hpc_pkg, hpc_if, the controller RTL and turn_cmd_checker.

module tb_top;
   import hpc_pkg::*;

   localparam int unsigned      TURN_RAMP     = 15;
   localparam logic [REQ_W-1:0] REQ_SPARE     = 2'd3;
   localparam int               SETTLE_CYCLES = 100;
   localparam int               NUM_PHASES    = 8;
   localparam int               PHASE_ITEMS   = 240;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   int unsigned           fail_count;
   int unsigned           pending;
   bit                    stall_en;

   hpc_req_if req_chan();
   hpc_rsp_if rsp_chan();

   heading_turn_pi_controller_unit #(.RAMP_STEPS(TURN_RAMP)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   turn_cmd_checker #(.RAMP_STEPS(TURN_RAMP)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_chan),
      .rsp_mon    (rsp_chan),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Hard stop if the run hangs
   initial begin
      #2000000;
      $display("tb_top: done, errors");
      $finish;
   end

   // Stall the result channel in short random bursts
   initial begin
      rsp_chan.ready = 1'b0;
      do @(negedge clock); while (reset);
      forever begin
         @(negedge clock);
         if (stall_en && $urandom_range(0, 4) == 0) begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
      end
   end

   function automatic int wrap_half(int a);
      if (a < -18000) return a + 36000;
      if (a > 18000) return a - 36000;
      return a;
   endfunction

   function automatic int pick_yaw();
      return int'($urandom_range(0, 36000)) - 18000;
   endfunction

   function automatic int pick_goal();
      int mag;
      case ($urandom_range(0, 3))
         0:       mag = $urandom_range(0, 36000);
         1:       mag = $urandom_range(300, 3000);
         2:       mag = 36000 - int'($urandom_range(0, 500));
         default: mag = $urandom_range(3000, 18000);
      endcase
      return ($urandom_range(0, 1) != 0) ? -mag : mag;
   endfunction

   // Present one request beat, hold until taken, then maybe leave a gap
   task automatic send_request(input logic [REQ_W-1:0] kind, input int yaw, input int goal,
                               input int use_fixed, input int speed, input int smooth);
      req_chan.valid           <= 1'b1;
      req_chan.req_type        <= kind;
      req_chan.yaw_now         <= YAW_W'(yaw);
      req_chan.goal_turn       <= GOAL_W'(goal);
      req_chan.use_fixed_speed <= 1'(use_fixed);
      req_chan.fixed_speed     <= VEL_W'(speed);
      req_chan.to_smoother     <= 1'(smooth);
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      if (stall_en && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
   endtask

   // Stop sending and wait until every result beat has come back
   task automatic drain();
      req_chan.valid <= 1'b0;
      do @(negedge clock); while (pending != 0);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input int unsigned val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_data  <= CSR_DATA_W'(val);
      @(negedge clock);
   endtask

   // Reprogram all registers while the block is idle
   task automatic load_settings(input int unsigned kp, input int unsigned ki,
                                input int unsigned vmax, input int unsigned vmin,
                                input int unsigned band);
      drain();
      repeat (4) @(negedge clock);
      write_csr(CSR_PROP_GAIN, kp);
      write_csr(CSR_INTEG_GAIN, ki);
      write_csr(CSR_MAX_VEL, vmax);
      write_csr(CSR_MIN_VEL, vmin);
      write_csr(CSR_DEAD_BAND, band);
      csr_wr_en <= 1'b0;
      @(negedge clock);
   endtask

   task automatic apply_phase(input int p);
      case (p)
         1: load_settings(20'hFFFFF, 20'hFFFFF, 4000, 4000, 0);
         2: load_settings(0, 0, 0, 0, 0);
         3: load_settings(11141, 500, 1150, 300, 18000);
         4: load_settings($urandom_range(0, 40000), $urandom_range(0, 3000), 500, 2000,
                          $urandom_range(0, 600));
         default: load_settings(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1048575)
                                                             : $urandom_range(0, 40000),
                                $urandom_range(0, 5000), $urandom_range(0, 4000),
                                $urandom_range(0, 4000), $urandom_range(0, 1000));
      endcase
   endtask

   // One well-formed turn: start, ticks walking the yaw toward the target, maybe a cancel
   task automatic run_turn(inout int sent);
      int yaw0, goal, tgt, span, steps, yaw;
      yaw0 = pick_yaw();
      goal = pick_goal();
      send_request(REQ_START, yaw0, goal, int'($urandom_range(0, 3) == 0),
                   $urandom_range(0, 4000), $urandom_range(0, 1));
      sent++;
      tgt   = wrap_half(yaw0 + goal);
      span  = wrap_half(tgt - yaw0);
      steps = $urandom_range(1, 24);
      for (int k = 1; k <= steps; k++) begin
         yaw = wrap_half(yaw0 + span * k / steps + int'($urandom_range(0, 200)) - 100);
         if (yaw > 18000) yaw = 18000;
         if (yaw < -18000) yaw = -18000;
         send_request(REQ_TICK, yaw, pick_goal(), $urandom_range(0, 1),
                      $urandom_range(0, 4000), $urandom_range(0, 1));
         sent++;
      end
      if ($urandom_range(0, 9) < 2) begin
         send_request(REQ_CANCEL, pick_yaw(), pick_goal(), $urandom_range(0, 1),
                      $urandom_range(0, 4000), $urandom_range(0, 1));
         sent++;
      end
   endtask

   // Loose beat of any kind, the unused request code among them
   task automatic send_noise();
      int pick;
      logic [REQ_W-1:0] kind;
      pick = $urandom_range(0, 19);
      if (pick == 0) kind = REQ_SPARE;
      else if (pick < 8) kind = REQ_CANCEL;
      else if (pick < 14) kind = REQ_START;
      else kind = REQ_TICK;
      send_request(kind, pick_yaw(), pick_goal(), $urandom_range(0, 1),
                   $urandom_range(0, 4000), $urandom_range(0, 1));
   endtask

   initial begin
      int sent;
      reset                    = 1'b1;
      stall_en                 = 1'b0;
      csr_wr_en                = 1'b0;
      csr_index                = '0;
      csr_data                 = '0;
      req_chan.valid           = 1'b0;
      req_chan.req_type        = REQ_TICK;
      req_chan.yaw_now         = '0;
      req_chan.goal_turn       = '0;
      req_chan.use_fixed_speed = 1'b0;
      req_chan.fixed_speed     = '0;
      req_chan.to_smoother     = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: idle requests, band hits, fixed and PI turns, restart, cancel
      send_request(REQ_TICK, 0, 0, 0, 0, 0);
      send_request(REQ_CANCEL, 0, 0, 0, 0, 0);
      send_request(REQ_SPARE, 0, 0, 0, 0, 0);
      send_request(REQ_START, 0, 0, 1, 4000, 1);
      send_request(REQ_START, -18000, 9000, 1, 4000, 1);
      send_request(REQ_TICK, -18000, 0, 0, 0, 0);
      send_request(REQ_SPARE, -18000, 0, 0, 0, 0);
      send_request(REQ_START, 18000, -9000, 0, 0, 0);
      send_request(REQ_TICK, 18000, 0, 0, 0, 0);
      send_request(REQ_TICK, 16000, 0, 0, 0, 0);
      send_request(REQ_TICK, 14000, 0, 0, 0, 0);
      send_request(REQ_TICK, 12000, 0, 0, 0, 0);
      send_request(REQ_TICK, 10000, 0, 0, 0, 0);
      send_request(REQ_TICK, 9100, 0, 0, 0, 0);
      send_request(REQ_TICK, 0, 0, 0, 0, 0);
      send_request(REQ_START, 17999, 36000, 0, 4000, 1);
      send_request(REQ_START, -18000, -36000, 1, 4000, 1);
      send_request(REQ_START, 18000, 18000, 1, 0, 0);
      send_request(REQ_TICK, 4000, 0, 0, 0, 0);
      send_request(REQ_CANCEL, 4000, 0, 0, 0, 0);
      send_request(REQ_START, 0, -20000, 1, 2500, 1);
      send_request(REQ_TICK, 5000, 0, 0, 0, 0);
      send_request(REQ_TICK, 16000, 0, 0, 0, 0);
      send_request(REQ_CANCEL, 0, 0, 0, 0, 0);

      // Random: one register setting per phase, mostly complete turns
      for (int p = 0; p < NUM_PHASES; p++) begin
         if (p != 0) apply_phase(p);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            stall_en <= (p != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 9) < 8) begin
               run_turn(sent);
            end else begin
               send_noise();
               sent++;
            end
            if ($urandom_range(0, 39) == 0) drain();
         end
      end

      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("tb_top: done, clean");
      end else begin
         $display("tb_top: done, errors");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/hpc_pkg.sv
rtl/hpc_if.sv
rtl/hpc_mac.sv
rtl/hpc_div.sv
rtl/heading_turn_pi_controller_unit.sv
rtl/hpc_checker.sv
verif/turn_cmd_checker.sv
verif/tb_top.sv
